/* hw/rtl/rau_pkg.sv */
// shared types and constants of the rational arithmetic unit
`default_nettype none
package rau_pkg;

  localparam int MAG_WIDTH_DEF = 16;
  localparam int NUM_W         = 33;
  localparam int DEN_W         = 32;
  localparam int OUT_TDATA_W   = 72;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DEN_ZERO = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MS_A = 2'd0,
    MS_B = 2'd1,
    MS_C = 2'd2
  } mstep_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MULA,
    S_MULB,
    S_MULC,
    S_COMB,
    S_GCD,
    S_GSH,
    S_DIVNI,
    S_DIVN,
    S_DIVDI,
    S_DIVD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic   load;
    logic   mul_en;
    mstep_t mul_step;
    logic   combine;
    logic   gcd_step;
    logic   gshift;
    logic   div_init;
    logic   div_sel_den;
    logic   div_step;
    logic   store_num;
    logic   store_den;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic num_zero;
    logic x_zero;
    logic y_nz;
    logic k_zero;
    logic div_done;
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/rau_ctrl.sv */
// sequencer of the rational arithmetic unit
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  wire  logic out_tready,
  output cmd_t       cmd,
  input  wire  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_MULA;
      S_MULA:  state_nxt = sts.err ? S_FIN : S_MULB;
      S_MULB:  state_nxt = S_MULC;
      S_MULC:  state_nxt = S_COMB;
      S_COMB:  state_nxt = S_GCD;
      S_GCD: begin
        if (sts.num_zero) state_nxt = S_FIN;
        else if (sts.x_zero) state_nxt = S_GSH;
      end
      S_GSH:   if (sts.k_zero) state_nxt = S_DIVNI;
      S_DIVNI: state_nxt = S_DIVN;
      S_DIVN:  if (sts.div_done) state_nxt = S_DIVDI;
      S_DIVDI: state_nxt = S_DIVD;
      S_DIVD:  if (sts.div_done) state_nxt = S_FIN;
      S_FIN:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd           = '0;
    cmd.mul_step  = MS_A;
    in_tready     = (state_r == S_IDLE);
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: cmd.load = in_tvalid;
      S_MULA: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MS_A;
      end
      S_MULB: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MS_B;
      end
      S_MULC: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MS_C;
      end
      S_COMB: cmd.combine = 1'b1;
      S_GCD:  cmd.gcd_step = !sts.num_zero && !sts.x_zero;
      S_GSH:  cmd.gshift = !sts.k_zero;
      S_DIVNI: cmd.div_init = 1'b1;
      S_DIVN: begin
        cmd.div_step  = !sts.div_done;
        cmd.store_num = sts.div_done;
      end
      S_DIVDI: begin
        cmd.div_init    = 1'b1;
        cmd.div_sel_den = 1'b1;
      end
      S_DIVD: begin
        cmd.div_step  = !sts.div_done;
        cmd.store_den = sts.div_done;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign out_tvalid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_MULA))
    else $error("accepted item did not start the multiply sequence");

  a_gcd_y_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GCD) |-> sts.y_nz)
    else $error("gcd operand y reached zero");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("result presented outside the finish state");

endmodule
`default_nettype wire

/* hw/rtl/rau_dp.sv */
// datapath: shared multiplier, combine, binary gcd and restoring divider
`default_nettype none
module rau_dp
  import rau_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) (
  input  wire  logic                                       clk,
  input  wire  logic [((4*MAG_WIDTH+4+7)/8)*8-1:0]         in_tdata,
  input  wire  cmd_t                                       cmd,
  output sts_t                                             sts,
  output logic [OUT_TDATA_W-1:0]                           out_tdata
);

  localparam int W   = MAG_WIDTH;
  localparam int PW  = 2*W+1;
  localparam int KW  = $clog2(PW+1);
  localparam int O_AN  = 2;
  localparam int O_ANM = 3;
  localparam int O_ADN = 3+W;
  localparam int O_BN  = 3+2*W;
  localparam int O_BNM = 4+2*W;
  localparam int O_BDN = 4+3*W;
  localparam logic [KW-1:0] DIV_LAST = KW'(PW);

  op_t            op_r;
  logic           an_r, bn_r, neg_r;
  logic [W-1:0]   anum_r, aden_r, bnum_r, bden_r;
  logic [2*W-1:0] sa_r, sb_r;
  logic [PW-1:0]  num_r, den_r, x_r, y_r, q_r, rem_r;
  logic [KW-1:0]  k_r, cnt_r;
  status_t        st_r;
  logic           res_neg_r;
  logic [NUM_W-1:0] res_num_r;
  logic [DEN_W-1:0] res_den_r;
  status_t        res_st_r;

  logic [W-1:0]   ma, mb, i_anum, i_aden, i_bnum, i_bden;
  logic [2*W-1:0] prod;
  logic [1:0]     i_op;
  status_t        i_st;
  logic           bs;
  logic [PW:0]    rem_sh;
  logic [PW-1:0]  rem_sub;
  logic [NUM_W+PW-1:0] num_ext;
  logic [DEN_W+PW-1:0] den_ext;

  assign i_op   = in_tdata[1:0];
  assign i_anum = in_tdata[O_ANM +: W];
  assign i_aden = in_tdata[O_ADN +: W];
  assign i_bnum = in_tdata[O_BNM +: W];
  assign i_bden = in_tdata[O_BDN +: W];

  always_comb begin
    if (i_aden == '0 || i_bden == '0) i_st = ST_DEN_ZERO;
    else if (op_t'(i_op) == OP_DIV && i_bnum == '0) i_st = ST_DIV_ZERO;
    else i_st = ST_OK;
  end

  // operand select for the shared multiplier
  always_comb begin
    ma = anum_r;
    mb = bden_r;
    case (cmd.mul_step)
      MS_A: begin
        ma = anum_r;
        mb = (op_r == OP_MUL) ? bnum_r : bden_r;
      end
      MS_B: begin
        ma = aden_r;
        mb = (op_r == OP_ADD || op_r == OP_SUB) ? bnum_r :
             (op_r == OP_MUL) ? bden_r : bnum_r;
      end
      MS_C: begin
        ma = aden_r;
        mb = bden_r;
      end
      default: begin
        ma = anum_r;
        mb = bden_r;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign bs      = (op_r == OP_SUB) ? ~bn_r : bn_r;
  assign rem_sh  = {rem_r, q_r[PW-1]};
  assign rem_sub = rem_sh[PW-1:0] - y_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(i_op);
      an_r   <= in_tdata[O_AN];
      bn_r   <= in_tdata[O_BN];
      anum_r <= i_anum;
      aden_r <= i_aden;
      bnum_r <= i_bnum;
      bden_r <= i_bden;
      st_r   <= i_st;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        MS_A: sa_r <= prod;
        MS_B: begin
          if (op_r == OP_ADD || op_r == OP_SUB) sb_r <= prod;
          else den_r <= {1'b0, prod};
        end
        MS_C: if (op_r == OP_ADD || op_r == OP_SUB) den_r <= {1'b0, prod};
        default: sa_r <= sa_r;
      endcase
    end
    if (cmd.combine) begin
      if (op_r == OP_MUL || op_r == OP_DIV) begin
        num_r <= {1'b0, sa_r};
        x_r   <= {1'b0, sa_r};
        neg_r <= an_r ^ bn_r;
      end else if (an_r == bs) begin
        num_r <= {1'b0, sa_r} + {1'b0, sb_r};
        x_r   <= {1'b0, sa_r} + {1'b0, sb_r};
        neg_r <= an_r;
      end else if (sa_r >= sb_r) begin
        num_r <= {1'b0, sa_r - sb_r};
        x_r   <= {1'b0, sa_r - sb_r};
        neg_r <= an_r;
      end else begin
        num_r <= {1'b0, sb_r - sa_r};
        x_r   <= {1'b0, sb_r - sa_r};
        neg_r <= bs;
      end
      y_r <= den_r;
      k_r <= '0;
    end
    // binary gcd, one step a cycle
    if (cmd.gcd_step) begin
      if (!x_r[0] && !y_r[0]) begin
        x_r <= x_r >> 1;
        y_r <= y_r >> 1;
        k_r <= k_r + 1'b1;
      end else if (!x_r[0]) begin
        x_r <= x_r >> 1;
      end else if (!y_r[0]) begin
        y_r <= y_r >> 1;
      end else if (x_r >= y_r) begin
        x_r <= x_r - y_r;
      end else begin
        y_r <= y_r - x_r;
      end
    end
    // restore the common power of two
    if (cmd.gshift) begin
      y_r <= y_r << 1;
      k_r <= k_r - 1'b1;
    end
    if (cmd.div_init) begin
      q_r   <= cmd.div_sel_den ? den_r : num_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, y_r}) begin
        rem_r <= rem_sub;
        q_r   <= {q_r[PW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[PW-1:0];
        q_r   <= {q_r[PW-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.store_num) num_r <= q_r;
    if (cmd.store_den) den_r <= q_r;
    if (cmd.out_load) begin
      if (st_r != ST_OK || num_r == '0) begin
        res_neg_r <= 1'b0;
        res_num_r <= '0;
        res_den_r <= {{(DEN_W-1){1'b0}}, 1'b1};
      end else begin
        res_neg_r <= neg_r;
        res_num_r <= num_ext[NUM_W-1:0];
        res_den_r <= den_ext[DEN_W-1:0];
      end
      res_st_r <= st_r;
    end
  end

  assign num_ext = {{NUM_W{1'b0}}, num_r};
  assign den_ext = {{DEN_W{1'b0}}, den_r};

  assign sts.err      = (st_r != ST_OK);
  assign sts.num_zero = (num_r == '0);
  assign sts.x_zero   = (x_r == '0);
  assign sts.y_nz     = (y_r != '0);
  assign sts.k_zero   = (k_r == '0);
  assign sts.div_done = (cnt_r == DIV_LAST);

  assign out_tdata = {{(OUT_TDATA_W-NUM_W-DEN_W-3){1'b0}}, res_st_r, res_den_r,
                      res_num_r, res_neg_r};

endmodule
`default_nettype wire

/* hw/rtl/rational_arithmetic_unit.sv */
// top level of the rational arithmetic unit
// Adds, subtracts, multiplies or divides two signed fractions (sign plus
// magnitude numerator and denominator) and returns the result reduced to
// lowest terms, with a sign and a status code (0 ok, 1 operand denominator
// zero, 2 division by zero). A zero result, and any error result, reads as
// positive 0/1. One item is worked on at a time: the input is ready only
// while the sequencer is idle. An item goes through an accept in the idle
// state, three steps (A, B, C) on the one shared multiplier, a combine step,
// a binary gcd of one step a cycle (a subtract being followed by a shift),
// one shift per common factor of two, then two restoring divisions of
// 2*MAG_WIDTH+1 steps, each with an init state before it and a store of the
// quotient after it, and a finish state; the gcd loop and the divider take
// most of an item's time. Items with a bad operand go from the first
// multiply state straight to finish, a zero result from the gcd state. The
// result sits in an output register so the block can go back to idle while
// the item waits to be taken.
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int MAG_WIDTH = MAG_WIDTH_DEF
) (
  input  wire  logic                                   clk,
  input  wire  logic                                   rst_n,
  input  wire  logic                                   in_tvalid,
  output logic                                         in_tready,
  // opcode, a_neg, a_num, a_den, b_neg, b_num, b_den, zero pad
  input  wire  logic [((4*MAG_WIDTH+4+7)/8)*8-1:0]     in_tdata,
  output logic                                         out_tvalid,
  input  wire  logic                                   out_tready,
  // res_neg, res_num, res_den, status, zero pad
  output logic [OUT_TDATA_W-1:0]                       out_tdata
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rau_dp #(
    .MAG_WIDTH (MAG_WIDTH)
  ) u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule
`default_nettype wire

/* verif/rational_arithmetic_unit_tb.sv */
// testbench for the rational arithmetic unit: random and directed fractions checked
`timescale 1ns / 100ps
`default_nettype none
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int MW     = MAG_WIDTH_DEF;
  localparam int IN_W   = ((4*MW+4+7)/8)*8;
  localparam int N_RAND = 1500;

  typedef struct packed {
    op_t         opcode;
    logic        a_neg;
    logic [15:0] a_num;
    logic [15:0] a_den;
    logic        b_neg;
    logic [15:0] b_num;
    logic [15:0] b_den;
  } frac_pair_t;

  typedef struct packed {
    logic        neg;
    logic [32:0] num;
    logic [31:0] den;
    status_t     status;
  } frac_res_t;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  frac_pair_t pending_items[$];
  frac_res_t  expected_results[$];
  int  error_count = 0;
  bit  stim_done   = 0;
  bit  no_idle     = 0;
  bit  hold_send   = 0;
  int  send_gap    = 0;
  int  recv_stall  = 0;

  rational_arithmetic_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // pack fields lowest first: opcode, a_neg, a_num, a_den, b_neg, b_num, b_den
  function automatic logic [IN_W-1:0] pack_pair(frac_pair_t p);
    logic [IN_W-1:0] d;
    d = '0;
    d[1:0]   = p.opcode;
    d[2]     = p.a_neg;
    d[18:3]  = p.a_num;
    d[34:19] = p.a_den;
    d[35]    = p.b_neg;
    d[51:36] = p.b_num;
    d[67:52] = p.b_den;
    return d;
  endfunction

  function automatic frac_res_t unpack_result(logic [OUT_TDATA_W-1:0] d);
    frac_res_t r;
    r.neg    = d[0];
    r.num    = d[33:1];
    r.den    = d[65:34];
    r.status = status_t'(d[67:66]);
    return r;
  endfunction

  function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // expected reduced fraction for one operand pair
  function automatic frac_res_t rational_result(frac_pair_t p);
    frac_res_t   r;
    logic [63:0] sa, sb, num, den, g;
    logic        bs, neg;
    r = '{neg: 1'b0, num: '0, den: 32'd1, status: ST_OK};
    if (p.a_den == 0 || p.b_den == 0) begin
      r.status = ST_DEN_ZERO;
      return r;
    end
    if (p.opcode == OP_DIV && p.b_num == 0) begin
      r.status = ST_DIV_ZERO;
      return r;
    end
    case (p.opcode)
      OP_ADD, OP_SUB: begin
        sa  = 64'(p.a_num) * 64'(p.b_den);
        sb  = 64'(p.b_num) * 64'(p.a_den);
        bs  = (p.opcode == OP_SUB) ? ~p.b_neg : p.b_neg;
        den = 64'(p.a_den) * 64'(p.b_den);
        if (p.a_neg == bs) begin
          num = sa + sb;
          neg = p.a_neg;
        end else if (sa >= sb) begin
          num = sa - sb;
          neg = p.a_neg;
        end else begin
          num = sb - sa;
          neg = bs;
        end
      end
      OP_MUL: begin
        num = 64'(p.a_num) * 64'(p.b_num);
        den = 64'(p.a_den) * 64'(p.b_den);
        neg = p.a_neg ^ p.b_neg;
      end
      default: begin
        num = 64'(p.a_num) * 64'(p.b_den);
        den = 64'(p.a_den) * 64'(p.b_num);
        neg = p.a_neg ^ p.b_neg;
      end
    endcase
    if (num == 0) return r;
    g = euclid_gcd(num, den);
    if (g > 1) begin
      num = num / g;
      den = den / g;
    end
    r.neg = neg;
    r.num = num[32:0];
    r.den = den[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [15:0] rand_mag();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hffff - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frac_pair_t rand_pair();
    frac_pair_t p;
    p.opcode = op_t'($urandom_range(0, 3));
    p.a_neg  = 1'($urandom_range(0, 1));
    p.b_neg  = 1'($urandom_range(0, 1));
    p.a_num  = rand_mag();
    p.b_num  = rand_mag();
    p.a_den  = rand_mag();
    p.b_den  = rand_mag();
    // mostly valid denominators so the arithmetic path gets most of the traffic
    if ($urandom_range(0, 19) != 0 && p.a_den == 0) p.a_den = 16'($urandom_range(1, 65535));
    if ($urandom_range(0, 19) != 0 && p.b_den == 0) p.b_den = 16'($urandom_range(1, 65535));
    // shared factors make the reduction do real work
    if ($urandom_range(0, 3) == 0) begin
      p.b_den = p.a_num;
      p.b_num = p.a_den;
    end
    return p;
  endfunction

  function automatic frac_pair_t mk(op_t op, logic an, logic [15:0] a_n, logic [15:0] a_d,
                                    logic bn, logic [15:0] b_n, logic [15:0] b_d);
    frac_pair_t p;
    p = '{opcode: op, a_neg: an, a_num: a_n, a_den: a_d, b_neg: bn, b_num: b_n, b_den: b_d};
    return p;
  endfunction

  // driver: presents queued items, idles in bursts, holds off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      // the current item (if any) is taken at this edge
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (!hold_send && pending_items.size() > 0) begin
        frac_pair_t p;
        p = pending_items.pop_front();
        expected_results.push_back(rational_result(p));
        in_tdata  <= pack_pair(p);
        in_tvalid <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 18);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor: takes results with random stalls and checks field by field
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        frac_res_t got, want;
        got = unpack_result(out_tdata);
        if (expected_results.size() == 0) begin
          $display("unexpected result item at %0t", $realtime);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.neg != want.neg)
            report_mismatch("res_neg", 64'(got.neg), 64'(want.neg));
          if (got.num != want.num)
            report_mismatch("res_num", 64'(got.num), 64'(want.num));
          if (got.den != want.den)
            report_mismatch("res_den", 64'(got.den), 64'(want.den));
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every operation, sign mixes, extremes and each error case
    pending_items.push_back(mk(OP_ADD, 0, 16'd1, 16'd2, 0, 16'd1, 16'd3));
    pending_items.push_back(mk(OP_SUB, 0, 16'd1, 16'd2, 0, 16'd1, 16'd2)); // zero result
    pending_items.push_back(mk(OP_SUB, 0, 16'd1, 16'd3, 0, 16'd1, 16'd2));
    pending_items.push_back(mk(OP_ADD, 1, 16'd5, 16'd6, 0, 16'd1, 16'd6));
    pending_items.push_back(mk(OP_MUL, 1, 16'd3, 16'd4, 1, 16'd8, 16'd9));
    pending_items.push_back(mk(OP_DIV, 0, 16'd3, 16'd4, 1, 16'd3, 16'd8));
    pending_items.push_back(mk(OP_ADD, 1, 16'hffff, 16'd1, 1, 16'hffff, 16'd1));
    pending_items.push_back(mk(OP_SUB, 0, 16'hffff, 16'd1, 1, 16'hffff, 16'd1));
    pending_items.push_back(mk(OP_MUL, 0, 16'hffff, 16'd1, 0, 16'hffff, 16'd1));
    pending_items.push_back(mk(OP_DIV, 1, 16'd1, 16'hffff, 0, 16'd1, 16'hffff));
    pending_items.push_back(mk(OP_ADD, 0, 16'd1, 16'hffff, 0, 16'd1, 16'hfffe));
    pending_items.push_back(mk(OP_MUL, 1, 16'd0, 16'd7, 0, 16'd5, 16'd3)); // negative zero
    pending_items.push_back(mk(OP_ADD, 1, 16'd0, 16'd7, 1, 16'd0, 16'd3));
    pending_items.push_back(mk(OP_ADD, 0, 16'd1, 16'd0, 0, 16'd1, 16'd1)); // bad a denominator
    pending_items.push_back(mk(OP_MUL, 1, 16'd1, 16'd1, 1, 16'd1, 16'd0)); // bad b denominator
    pending_items.push_back(mk(OP_DIV, 0, 16'd1, 16'd0, 0, 16'd0, 16'd0)); // both errors
    pending_items.push_back(mk(OP_DIV, 1, 16'd4, 16'd5, 1, 16'd0, 16'd9)); // divide by zero
    pending_items.push_back(mk(OP_DIV, 0, 16'd0, 16'd5, 0, 16'd3, 16'd9));
    pending_items.push_back(mk(OP_SUB, 1, 16'h8000, 16'h4000, 0, 16'h4000, 16'h8000));
    pending_items.push_back(mk(OP_DIV, 0, 16'hffff, 16'hffff, 1, 16'hffff, 16'hffff));

    // hold off until the directed items have all come back
    wait (pending_items.size() == 0);
    hold_send = 1'b1;
    wait (expected_results.size() == 0);
    @(posedge clk);
    hold_send = 1'b0;

    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND - 150) no_idle = 1'b1;
      pending_items.push_back(rand_pair());
      if (pending_items.size() > 8) wait (pending_items.size() <= 4);
    end
    wait (pending_items.size() == 0 && !in_tvalid);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk);
    if (error_count == 0)
      $display("rational_arithmetic_unit_tb OK");
    else
      $display("rational_arithmetic_unit_tb NOT OK");
    $finish;
  end

  // slowest run: 1520 items of block work, send gap and stall, then several times over
  initial begin
    #(12 * 2000000);
    $display("rational_arithmetic_unit_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
